>>> hdl/dtbms_pkg.sv
`timescale 1ns / 1ps

package dtbms_pkg;

	localparam int QUEUE_DEPTH       = 16;
	localparam int MAX_LENGTH        = 4095;
	localparam int FRACTION_BITS     = 32;
	localparam int MICROS_PER_SECOND = 1000000;

	// field widths
	localparam int KIND_W     = 2;
	localparam int LEN_W      = 12;
	localparam int TAG_W      = 16;
	localparam int ELAPSED_W  = 32;
	localparam int EV_W       = 3;
	localparam int QMSG_W     = 5;
	localparam int QCHR_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int MCAP_W     = 5;
	localparam int CCAP_W     = 16;
	localparam int RATE_W     = 32;

	localparam int IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W = LEN_W + TAG_W;

	// token arithmetic
	localparam int MTOK_W      = MCAP_W + FRACTION_BITS;
	localparam int CTOK_W      = CCAP_W + FRACTION_BITS;
	localparam int PROD_W      = ELAPSED_W + RATE_W;
	localparam int DIV_DIGIT_W = 4;
	localparam int DIV_STEPS   = PROD_W / DIV_DIGIT_W;
	localparam int DSTEP_W     = $clog2(DIV_STEPS);
	localparam int REM_W       = $clog2(MICROS_PER_SECOND);
	localparam int GAIN_W      = PROD_W - REM_W + 1;
	localparam int SUM_W       = ((CTOK_W > GAIN_W) ? CTOK_W : GAIN_W) + 1;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [IDX_W:0]     slot_sum_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [CCAP_W-1:0]  chr_t;
	typedef logic [CCAP_W:0]    chr_ext_t;
	typedef logic [QMSG_W-1:0]  qmsg_t;
	typedef logic [MTOK_W-1:0]  mtok_t;
	typedef logic [CTOK_W-1:0]  ctok_t;
	typedef logic [PROD_W-1:0]  prod_t;
	typedef logic [REM_W-1:0]   rem_t;
	typedef logic [REM_W:0]     rem_ext_t;
	typedef logic [GAIN_W-1:0]  gain_t;
	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [DSTEP_W-1:0] dstep_t;

	localparam rem_ext_t DIVISOR = rem_ext_t'(MICROS_PER_SECOND);

	typedef enum logic [KIND_W-1:0] {
		KIND_ENQUEUE = 2'd0,
		KIND_TICK    = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	typedef enum logic [EV_W-1:0] {
		EV_ACCEPTED = 3'd0,
		EV_REJECTED = 3'd1,
		EV_SENT     = 3'd2,
		EV_DROPPED  = 3'd3,
		EV_DONE     = 3'd4
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MSG_CAPACITY = 3'd0,
		REG_CHR_CAPACITY = 3'd1,
		REG_MSG_RATE     = 3'd2,
		REG_CHR_RATE     = 3'd3,
		REG_MSG_BURST    = 3'd4,
		REG_CHR_BURST    = 3'd5
	} reg_index_t;

	localparam logic [MCAP_W-1:0] RST_MSG_CAPACITY = 5'd16;
	localparam logic [CCAP_W-1:0] RST_CHR_CAPACITY = 16'd4096;
	localparam logic [RATE_W-1:0] RST_MSG_RATE     = 32'd4295;
	localparam logic [RATE_W-1:0] RST_CHR_RATE     = 32'd429497;
	localparam logic [MCAP_W-1:0] RST_MSG_BURST    = 5'd4;
	localparam logic [CCAP_W-1:0] RST_CHR_BURST    = 16'd1024;

	typedef struct packed {
		logic   load_item;
		logic   mul;
		logic   div_step;
		logic   refill;
		logic   enqueue;
		logic   restart;
		logic   pop;
		logic   spend;
		logic   emit;
		event_t ev;
		logic   last;
	} dp_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              enq_ok;
		logic              empty;
		logic              oversize;
		logic              can_send;
		logic              out_free;
	} dp_status_t;

endpackage

>>> hdl/dtbms_ram.sv
`timescale 1ns / 1ps

module dtbms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/dtbms_ctrl.sv
`timescale 1ns / 1ps

module dtbms_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  dtbms_pkg::dp_status_t  status,
	output dtbms_pkg::dp_cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_ENQ,
		S_MUL,
		S_DIV,
		S_REFILL,
		S_DROP,
		S_SEND
	} state_t;

	state_t            state_q;
	state_t            state_d;
	dtbms_pkg::dstep_t step_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (status.kind)
					dtbms_pkg::KIND_ENQUEUE: state_d = S_ENQ;
					dtbms_pkg::KIND_TICK:    state_d = S_MUL;
					dtbms_pkg::KIND_RESTART: begin
						cmd.restart = 1'b1;
						state_d     = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ENQ: begin
				if (status.out_free) begin
					cmd.enqueue = 1'b1;
					cmd.emit    = 1'b1;
					cmd.last    = 1'b1;
					cmd.ev      = status.enq_ok ? dtbms_pkg::EV_ACCEPTED
					                            : dtbms_pkg::EV_REJECTED;
					state_d     = S_IDLE;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == dtbms_pkg::dstep_t'(dtbms_pkg::DIV_STEPS - 1)) begin
					state_d = S_REFILL;
				end
			end
			S_REFILL: begin
				cmd.refill = 1'b1;
				state_d    = S_DROP;
			end
			S_DROP: begin
				// drop oversize head words, then move on to sending
				if (!status.empty && status.oversize) begin
					if (status.out_free) begin
						cmd.pop  = 1'b1;
						cmd.emit = 1'b1;
						cmd.ev   = dtbms_pkg::EV_DROPPED;
					end
				end else begin
					state_d = S_SEND;
				end
			end
			S_SEND: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (!status.empty && status.can_send) begin
						cmd.pop   = 1'b1;
						cmd.spend = 1'b1;
						cmd.ev    = dtbms_pkg::EV_SENT;
					end else begin
						cmd.ev   = dtbms_pkg::EV_DONE;
						cmd.last = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MUL) begin
				step_q <= '0;
			end else if (state_q == S_DIV) begin
				step_q <= step_q + dtbms_pkg::dstep_t'(1);
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

>>> hdl/dtbms_dp.sv
`timescale 1ns / 1ps

module dtbms_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	// input word
	input  logic [dtbms_pkg::KIND_W-1:0]        kind,
	input  logic [dtbms_pkg::LEN_W-1:0]         message_length,
	input  logic [dtbms_pkg::TAG_W-1:0]         message_tag,
	input  logic [dtbms_pkg::ELAPSED_W-1:0]     elapsed_us,
	// configuration
	input  logic                                cfg_wr,
	input  logic [dtbms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dtbms_pkg::CFG_DATA_W-1:0]    cfg_data,
	// result word
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dtbms_pkg::EV_W-1:0]          event_res,
	output logic [dtbms_pkg::TAG_W-1:0]         out_tag,
	output logic [dtbms_pkg::LEN_W-1:0]         out_length,
	output logic [dtbms_pkg::QMSG_W-1:0]        queued_messages,
	output logic [dtbms_pkg::QCHR_W-1:0]        queued_characters,
	output logic                                last,
	// controller
	input  dtbms_pkg::dp_cmd_t                  cmd,
	output dtbms_pkg::dp_status_t               status,
	// descriptor store
	output logic                                ram_we,
	output logic [dtbms_pkg::IDX_W-1:0]         ram_waddr,
	output logic [dtbms_pkg::ENTRY_W-1:0]       ram_wdata,
	output logic [dtbms_pkg::IDX_W-1:0]         ram_raddr,
	input  logic [dtbms_pkg::ENTRY_W-1:0]       ram_rdata
);

	// item
	logic [dtbms_pkg::KIND_W-1:0]    item_kind_q;
	logic [dtbms_pkg::LEN_W-1:0]     item_len_q;
	logic [dtbms_pkg::TAG_W-1:0]     item_tag_q;
	logic [dtbms_pkg::ELAPSED_W-1:0] item_elapsed_q;

	// configuration
	logic [dtbms_pkg::MCAP_W-1:0] mcap_q;
	logic [dtbms_pkg::CCAP_W-1:0] ccap_q;
	logic [dtbms_pkg::RATE_W-1:0] mrate_q;
	logic [dtbms_pkg::RATE_W-1:0] crate_q;
	logic [dtbms_pkg::MCAP_W-1:0] mburst_q;
	logic [dtbms_pkg::CCAP_W-1:0] cburst_q;

	// queue and buckets
	dtbms_pkg::idx_t  head_q;
	dtbms_pkg::cnt_t  count_q;
	dtbms_pkg::chr_t  ccount_q;
	dtbms_pkg::mtok_t mtok_q;
	dtbms_pkg::ctok_t ctok_q;

	// refill divider, one lane per bucket
	dtbms_pkg::prod_t mdiv_q;
	dtbms_pkg::prod_t cdiv_q;
	dtbms_pkg::rem_t  mrem_q;
	dtbms_pkg::rem_t  crem_q;

	// result register
	logic                           out_valid_q;
	dtbms_pkg::event_t              event_q;
	logic [dtbms_pkg::TAG_W-1:0]    tag_q;
	logic [dtbms_pkg::LEN_W-1:0]    len_q;
	dtbms_pkg::qmsg_t               qmsg_q;
	dtbms_pkg::chr_t                qchr_q;
	logic                           last_q;

	dtbms_pkg::idx_t      head_inc;
	dtbms_pkg::idx_t      head_d;
	dtbms_pkg::cnt_t      count_d;
	dtbms_pkg::chr_t      ccount_d;
	dtbms_pkg::slot_sum_t slot_sum;
	dtbms_pkg::idx_t      tail;
	logic [dtbms_pkg::LEN_W-1:0] head_len;
	logic [dtbms_pkg::TAG_W-1:0] head_tag;
	logic                 enq_ok;
	dtbms_pkg::prod_t     mprod;
	dtbms_pkg::prod_t     cprod;
	logic [dtbms_pkg::REM_W+dtbms_pkg::DIV_DIGIT_W-1:0] mstep;
	logic [dtbms_pkg::REM_W+dtbms_pkg::DIV_DIGIT_W-1:0] cstep;
	dtbms_pkg::sum_t      msum;
	dtbms_pkg::sum_t      csum;
	dtbms_pkg::sum_t      mlimit;
	dtbms_pkg::sum_t      climit;

	// four restoring steps on the narrow remainder
	function automatic logic [dtbms_pkg::REM_W+dtbms_pkg::DIV_DIGIT_W-1:0] div_digit(
		input dtbms_pkg::rem_t                  rem_in,
		input logic [dtbms_pkg::DIV_DIGIT_W-1:0] bits_in
	);
		dtbms_pkg::rem_ext_t                 t;
		dtbms_pkg::rem_t                     r;
		logic [dtbms_pkg::DIV_DIGIT_W-1:0]   q;
		r = rem_in;
		q = '0;
		for (int i = dtbms_pkg::DIV_DIGIT_W - 1; i >= 0; i--) begin
			t = {r, bits_in[i]};
			if (t >= dtbms_pkg::DIVISOR) begin
				t    = t - dtbms_pkg::DIVISOR;
				q[i] = 1'b1;
			end
			r = t[dtbms_pkg::REM_W-1:0];
		end
		return {r, q};
	endfunction

	assign head_len = ram_rdata[dtbms_pkg::ENTRY_W-1:dtbms_pkg::TAG_W];
	assign head_tag = ram_rdata[dtbms_pkg::TAG_W-1:0];

	always_comb begin
		head_inc = (head_q == dtbms_pkg::idx_t'(dtbms_pkg::QUEUE_DEPTH - 1))
		           ? '0 : head_q + dtbms_pkg::idx_t'(1);
		slot_sum = dtbms_pkg::slot_sum_t'(head_q) + dtbms_pkg::slot_sum_t'(count_q);
		if (slot_sum >= dtbms_pkg::slot_sum_t'(dtbms_pkg::QUEUE_DEPTH)) begin
			tail = dtbms_pkg::idx_t'(slot_sum - dtbms_pkg::slot_sum_t'(dtbms_pkg::QUEUE_DEPTH));
		end else begin
			tail = dtbms_pkg::idx_t'(slot_sum);
		end
		enq_ok = (int'(item_len_q) <= dtbms_pkg::MAX_LENGTH)
		      && (int'(count_q) < int'(mcap_q))
		      && (int'(count_q) < dtbms_pkg::QUEUE_DEPTH)
		      && (dtbms_pkg::chr_ext_t'(ccount_q) + dtbms_pkg::chr_ext_t'(item_len_q)
		          <= dtbms_pkg::chr_ext_t'(ccap_q));
	end

	// queue occupancy after this cycle's action
	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		ccount_d = ccount_q;
		if (cmd.restart) begin
			head_d   = '0;
			count_d  = '0;
			ccount_d = '0;
		end else if (cmd.pop) begin
			head_d   = head_inc;
			count_d  = count_q - dtbms_pkg::cnt_t'(1);
			ccount_d = ccount_q - dtbms_pkg::chr_t'(head_len);
		end else if (cmd.enqueue && enq_ok) begin
			count_d  = count_q + dtbms_pkg::cnt_t'(1);
			ccount_d = ccount_q + dtbms_pkg::chr_t'(item_len_q);
		end
	end

	// read ahead at the next head so the head word is always current
	assign ram_raddr = head_d;
	assign ram_we    = cmd.enqueue && enq_ok;
	assign ram_waddr = tail;
	assign ram_wdata = {item_len_q, item_tag_q};

	assign mprod = item_elapsed_q * mrate_q;
	assign cprod = item_elapsed_q * crate_q;
	assign mstep = div_digit(mrem_q,
		mdiv_q[dtbms_pkg::PROD_W-1 -: dtbms_pkg::DIV_DIGIT_W]);
	assign cstep = div_digit(crem_q,
		cdiv_q[dtbms_pkg::PROD_W-1 -: dtbms_pkg::DIV_DIGIT_W]);

	assign msum   = dtbms_pkg::sum_t'(mtok_q)
	              + dtbms_pkg::sum_t'(dtbms_pkg::gain_t'(mdiv_q));
	assign csum   = dtbms_pkg::sum_t'(ctok_q)
	              + dtbms_pkg::sum_t'(dtbms_pkg::gain_t'(cdiv_q));
	assign mlimit = dtbms_pkg::sum_t'({mcap_q, {dtbms_pkg::FRACTION_BITS{1'b0}}});
	assign climit = dtbms_pkg::sum_t'({ccap_q, {dtbms_pkg::FRACTION_BITS{1'b0}}});

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_kind_q    <= kind;
			item_len_q     <= message_length;
			item_tag_q     <= message_tag;
			item_elapsed_q <= elapsed_us;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcap_q   <= dtbms_pkg::RST_MSG_CAPACITY;
			ccap_q   <= dtbms_pkg::RST_CHR_CAPACITY;
			mrate_q  <= dtbms_pkg::RST_MSG_RATE;
			crate_q  <= dtbms_pkg::RST_CHR_RATE;
			mburst_q <= dtbms_pkg::RST_MSG_BURST;
			cburst_q <= dtbms_pkg::RST_CHR_BURST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				dtbms_pkg::REG_MSG_CAPACITY: mcap_q   <= cfg_data[dtbms_pkg::MCAP_W-1:0];
				dtbms_pkg::REG_CHR_CAPACITY: ccap_q   <= cfg_data[dtbms_pkg::CCAP_W-1:0];
				dtbms_pkg::REG_MSG_RATE:     mrate_q  <= cfg_data[dtbms_pkg::RATE_W-1:0];
				dtbms_pkg::REG_CHR_RATE:     crate_q  <= cfg_data[dtbms_pkg::RATE_W-1:0];
				dtbms_pkg::REG_MSG_BURST:    mburst_q <= cfg_data[dtbms_pkg::MCAP_W-1:0];
				dtbms_pkg::REG_CHR_BURST:    cburst_q <= cfg_data[dtbms_pkg::CCAP_W-1:0];
				default: ;
			endcase
		end
	end

	// queue pointers and token buckets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			ccount_q <= '0;
			mtok_q   <= '0;
			ctok_q   <= '0;
		end else begin
			head_q   <= head_d;
			count_q  <= count_d;
			ccount_q <= ccount_d;
			if (cmd.restart) begin
				mtok_q <= {mburst_q, {dtbms_pkg::FRACTION_BITS{1'b0}}};
				ctok_q <= {cburst_q, {dtbms_pkg::FRACTION_BITS{1'b0}}};
			end else if (cmd.refill) begin
				// cap at the bucket size, also when the burst left it above
				mtok_q <= (msum > mlimit) ? dtbms_pkg::mtok_t'(mlimit)
				                          : dtbms_pkg::mtok_t'(msum);
				ctok_q <= (csum > climit) ? dtbms_pkg::ctok_t'(climit)
				                          : dtbms_pkg::ctok_t'(csum);
			end else if (cmd.spend) begin
				mtok_q[dtbms_pkg::MTOK_W-1:dtbms_pkg::FRACTION_BITS] <=
					mtok_q[dtbms_pkg::MTOK_W-1:dtbms_pkg::FRACTION_BITS]
					- logic'(1'b1);
				ctok_q[dtbms_pkg::CTOK_W-1:dtbms_pkg::FRACTION_BITS] <=
					ctok_q[dtbms_pkg::CTOK_W-1:dtbms_pkg::FRACTION_BITS]
					- dtbms_pkg::chr_t'(head_len);
			end
		end
	end

	// product, then quotient by one million built up in the same register
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			mdiv_q <= mprod;
			cdiv_q <= cprod;
			mrem_q <= '0;
			crem_q <= '0;
		end else if (cmd.div_step) begin
			mdiv_q <= {mdiv_q[dtbms_pkg::PROD_W-dtbms_pkg::DIV_DIGIT_W-1:0],
			           mstep[dtbms_pkg::DIV_DIGIT_W-1:0]};
			cdiv_q <= {cdiv_q[dtbms_pkg::PROD_W-dtbms_pkg::DIV_DIGIT_W-1:0],
			           cstep[dtbms_pkg::DIV_DIGIT_W-1:0]};
			mrem_q <= mstep[dtbms_pkg::REM_W+dtbms_pkg::DIV_DIGIT_W-1:dtbms_pkg::DIV_DIGIT_W];
			crem_q <= cstep[dtbms_pkg::REM_W+dtbms_pkg::DIV_DIGIT_W-1:dtbms_pkg::DIV_DIGIT_W];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			event_q <= cmd.ev;
			last_q  <= cmd.last;
			qmsg_q  <= dtbms_pkg::qmsg_t'(count_d);
			qchr_q  <= ccount_d;
			unique case (cmd.ev) inside
				dtbms_pkg::EV_ACCEPTED, dtbms_pkg::EV_REJECTED: begin
					tag_q <= item_tag_q;
					len_q <= item_len_q;
				end
				dtbms_pkg::EV_SENT, dtbms_pkg::EV_DROPPED: begin
					tag_q <= head_tag;
					len_q <= head_len;
				end
				default: begin
					tag_q <= '0;
					len_q <= '0;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign event_res         = event_q;
	assign out_tag           = tag_q;
	assign out_length        = len_q;
	assign queued_messages   = qmsg_q;
	assign queued_characters = qchr_q;
	assign last              = last_q;

	always_comb begin
		status          = '0;
		status.kind     = item_kind_q;
		status.enq_ok   = enq_ok;
		status.empty    = (count_q == '0);
		status.oversize = dtbms_pkg::chr_t'(head_len) > cburst_q;
		status.can_send = (mtok_q[dtbms_pkg::MTOK_W-1:dtbms_pkg::FRACTION_BITS] != '0)
		               && (dtbms_pkg::chr_t'(head_len)
		                   <= ctok_q[dtbms_pkg::CTOK_W-1:dtbms_pkg::FRACTION_BITS]);
		status.out_free = !out_valid_q || !out_stall;
	end

endmodule

>>> hdl/dual_token_bucket_message_shaper_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Word
// in        to block   in_valid / in_stall    kind, message_length, message_tag, elapsed_us
// out       from block out_valid / out_stall  event_res, out_tag, out_length,
//                                             queued_messages, queued_characters, last
// cfg       to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time. Enqueue: decode, then one result word. Restart: cleared at decode, no result.
// Tick: refill (one multiply, 16 divide steps of 4 bits by one million, a bucket update),
// then one result word per drop or send and one done word.
// Drop and send take one entry a cycle unless stalled, set by the store's single read port.
// A stalled result register holds the sequencer; reset clears queue and buckets at once.

module dual_token_bucket_message_shaper_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dtbms_pkg::KIND_W-1:0]        kind,
	input  logic [dtbms_pkg::LEN_W-1:0]         message_length,
	input  logic [dtbms_pkg::TAG_W-1:0]         message_tag,
	input  logic [dtbms_pkg::ELAPSED_W-1:0]     elapsed_us,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dtbms_pkg::EV_W-1:0]          event_res,
	output logic [dtbms_pkg::TAG_W-1:0]         out_tag,
	output logic [dtbms_pkg::LEN_W-1:0]         out_length,
	output logic [dtbms_pkg::QMSG_W-1:0]        queued_messages,
	output logic [dtbms_pkg::QCHR_W-1:0]        queued_characters,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dtbms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dtbms_pkg::CFG_DATA_W-1:0]    cfg_data
);

	dtbms_pkg::dp_cmd_t    cmd;
	dtbms_pkg::dp_status_t status;
	logic                              ram_we;
	logic [dtbms_pkg::IDX_W-1:0]       ram_waddr;
	logic [dtbms_pkg::ENTRY_W-1:0]     ram_wdata;
	logic [dtbms_pkg::IDX_W-1:0]       ram_raddr;
	logic [dtbms_pkg::ENTRY_W-1:0]     ram_rdata;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	dtbms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	dtbms_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.kind              (kind),
		.message_length    (message_length),
		.message_tag       (message_tag),
		.elapsed_us        (elapsed_us),
		.cfg_wr            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.event_res         (event_res),
		.out_tag           (out_tag),
		.out_length        (out_length),
		.queued_messages   (queued_messages),
		.queued_characters (queued_characters),
		.last              (last),
		.cmd               (cmd),
		.status            (status),
		.ram_we            (ram_we),
		.ram_waddr         (ram_waddr),
		.ram_wdata         (ram_wdata),
		.ram_raddr         (ram_raddr),
		.ram_rdata         (ram_rdata)
	);

	dtbms_ram #(
		.WIDTH (dtbms_pkg::ENTRY_W),
		.DEPTH (dtbms_pkg::QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

>>> hdl/dtbms_checker.sv
`timescale 1ns / 1ps

module dtbms_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic [dtbms_pkg::KIND_W-1:0]        kind,
	input logic [dtbms_pkg::LEN_W-1:0]         message_length,
	input logic [dtbms_pkg::TAG_W-1:0]         message_tag,
	input logic [dtbms_pkg::ELAPSED_W-1:0]     elapsed_us,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [dtbms_pkg::EV_W-1:0]          event_res,
	input logic [dtbms_pkg::TAG_W-1:0]         out_tag,
	input logic [dtbms_pkg::LEN_W-1:0]         out_length,
	input logic [dtbms_pkg::QMSG_W-1:0]        queued_messages,
	input logic [dtbms_pkg::QCHR_W-1:0]        queued_characters,
	input logic                                last,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic [dtbms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [dtbms_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res)
			&& $stable(out_tag) && $stable(out_length) && $stable(last))
		else $error("result word changed under stall");

	// last marks exactly the closing word of an item
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (event_res != dtbms_pkg::EV_SENT
			&& event_res != dtbms_pkg::EV_DROPPED)))
		else $error("last flag does not match event");

	// done word carries no message
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == dtbms_pkg::EV_DONE |-> out_tag == '0 && out_length == '0)
		else $error("done word carries a message");

	// an accepted word keeps the block busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken straight after the first");

endmodule

bind dual_token_bucket_message_shaper_top dtbms_checker u_checker (.*);
